FILE: src/pas_pkg.sv
// Shared types and constants for the periodic alarm scheduler.
package pas_pkg;

    localparam int ALARM_SLOTS = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int COUNT_W     = $clog2(ALARM_SLOTS + 1);
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);
    localparam int EVENT_W     = 8;
    localparam int TIME_W      = 32;
    localparam int PERIOD_W    = 31;
    localparam int BIT_CNT_W   = $clog2(TIME_W);

    localparam logic [TIME_W-1:0] PERIODIC_FLAG = 32'h8000_0000;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic KIND_FIRED    = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [EVENT_W-1:0] event_id;
        logic [TIME_W-1:0]  delay_word;
        logic [TIME_W-1:0]  current_time;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [EVENT_W-1:0] fired_event;
        logic               last;
    } evt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_SCAN,
        ST_OVERFLOW,
        ST_TICK_CHECK,
        ST_TICK_DIV,
        ST_TICK_FIRE,
        ST_TICK_FLUSH
    } state_t;

endpackage

FILE: src/periodic_alarm_scheduler.sv
// Alarm slot table with serial remainder check on each tick.
//
//  channel | direction | payload         | beat
//  cmd     | in        | pas_pkg::cmd_t  | cmd_valid && cmd_ready
//  evt     | out       | pas_pkg::evt_t  | evt_valid && evt_ready
//
// A set or cancel is accepted, then walks the slots in order until it finds a matching id
// or free slot, or reaches the last slot. An overflow beat waits for a free output register.
// A tick checks each slot in turn; for every active slot with nonzero period the
// remainder of current_time by the period is formed one bit per cycle, and waits on
// evt_ready can hold the scan.
// Reset clears the whole slot table at once; cmd is taken only when the block is idle.
// A stalled evt beat holds the scan; a found alarm is held back one beat so that the
// final result of a tick can carry last.
module periodic_alarm_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pas_pkg::cmd_t cmd,
    output logic          evt_valid,
    input  logic          evt_ready,
    output pas_pkg::evt_t evt
);

    localparam logic [pas_pkg::SLOT_W-1:0] LAST_SLOT =
        pas_pkg::SLOT_W'(pas_pkg::ALARM_SLOTS - 1);
    localparam logic [pas_pkg::BIT_CNT_W-1:0] LAST_BIT =
        pas_pkg::BIT_CNT_W'(pas_pkg::TIME_W - 1);

    // Slot table
    logic [pas_pkg::ALARM_SLOTS-1:0] active_reg;
    logic [pas_pkg::ALARM_SLOTS-1:0] periodic_reg;
    logic [pas_pkg::PERIOD_W-1:0]    period_reg [pas_pkg::ALARM_SLOTS];
    logic [pas_pkg::EVENT_W-1:0]     event_reg  [pas_pkg::ALARM_SLOTS];
    logic [pas_pkg::COUNT_W-1:0]     count_reg, count_next;

    // Sequencer state
    pas_pkg::state_t                state_reg, state_next;
    logic [pas_pkg::SLOT_W-1:0]     idx_reg, idx_next;
    logic                           cancel_reg, cancel_next;
    logic [pas_pkg::EVENT_W-1:0]    ev_reg, ev_next;
    logic [pas_pkg::TIME_W-1:0]     dw_reg, dw_next;
    logic [pas_pkg::TIME_W-1:0]     now_reg, now_next;

    // Serial remainder
    logic [pas_pkg::TIME_W-1:0]     sh_reg, sh_next;
    logic [pas_pkg::PERIOD_W-1:0]   rem_reg, rem_next;
    logic [pas_pkg::BIT_CNT_W-1:0]  bit_reg, bit_next;

    // Held-back result and output register
    logic                           pend_valid_reg, pend_valid_next;
    logic [pas_pkg::EVENT_W-1:0]    pend_event_reg, pend_event_next;
    logic [pas_pkg::FOUND_W-1:0]    found_reg, found_next;
    logic                           out_valid_reg, out_valid_next;
    pas_pkg::evt_t                  out_reg, out_next;

    // Table write strobes
    logic arm_we;
    logic free_we;

    // Current slot view
    logic                         cur_active;
    logic                         cur_periodic;
    logic [pas_pkg::PERIOD_W-1:0] cur_period;
    logic [pas_pkg::EVENT_W-1:0]  cur_event;
    logic                         out_free;
    logic [pas_pkg::TIME_W-1:0]   trial;
    logic [pas_pkg::TIME_W-1:0]   divisor;
    logic [pas_pkg::TIME_W-1:0]   diff;

    assign cur_active   = active_reg[idx_reg];
    assign cur_periodic = periodic_reg[idx_reg];
    assign cur_period   = period_reg[idx_reg];
    assign cur_event    = event_reg[idx_reg];
    assign out_free     = !out_valid_reg || evt_ready;

    // One restoring step: shift in the next dividend bit, subtract when it fits
    assign trial   = {rem_reg, sh_reg[pas_pkg::TIME_W-1]};
    assign divisor = {1'b0, cur_period};
    assign diff    = trial - divisor;

    assign cmd_ready = (state_reg == pas_pkg::ST_IDLE);
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pas_pkg::ST_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cancel_reg     <= cancel_next;
        ev_reg         <= ev_next;
        dw_reg         <= dw_next;
        now_reg        <= now_next;
        sh_reg         <= sh_next;
        rem_reg        <= rem_next;
        bit_reg        <= bit_next;
        pend_event_reg <= pend_event_next;
        out_reg        <= out_next;
    end

    // Slot table, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            periodic_reg <= '0;
            for (int i = 0; i < pas_pkg::ALARM_SLOTS; i++)
            begin
                period_reg[i] <= '0;
                event_reg[i]  <= '0;
            end
        end
        else
        begin
            if (arm_we)
            begin
                active_reg[idx_reg]   <= 1'b1;
                periodic_reg[idx_reg] <= (dw_reg & pas_pkg::PERIODIC_FLAG) != '0;
                period_reg[idx_reg]   <= dw_reg[pas_pkg::PERIOD_W-1:0];
                event_reg[idx_reg]    <= ev_reg;
            end
            else if (free_we)
            begin
                active_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        cancel_next     = cancel_reg;
        ev_next         = ev_reg;
        dw_next         = dw_reg;
        now_next        = now_reg;
        sh_next         = sh_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        pend_valid_next = pend_valid_reg;
        pend_event_next = pend_event_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !evt_ready;
        out_next        = out_reg;
        arm_we          = 1'b0;
        free_we         = 1'b0;

        unique case (state_reg)
            pas_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ev_next         = cmd.event_id;
                    dw_next         = cmd.delay_word;
                    now_next        = cmd.current_time;
                    cancel_next     = (cmd.delay_word == '0);
                    idx_next        = '0;
                    found_next      = '0;
                    pend_valid_next = 1'b0;
                    if (cmd.mode == pas_pkg::MODE_TICK)
                        state_next = pas_pkg::ST_TICK_CHECK;
                    else if (cmd.delay_word != '0 &&
                             count_reg >= pas_pkg::COUNT_W'(pas_pkg::ALARM_SLOTS))
                        state_next = pas_pkg::ST_OVERFLOW;
                    else
                        state_next = pas_pkg::ST_SET_SCAN;
                end
            end

            // Walk slots for the first matching id (cancel) or first free slot (arm)
            pas_pkg::ST_SET_SCAN:
            begin
                if (cancel_reg)
                begin
                    if (cur_event == ev_reg)
                    begin
                        if (cur_active)
                        begin
                            free_we    = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        state_next = pas_pkg::ST_IDLE;
                    end
                    else if (idx_reg == LAST_SLOT)
                        state_next = pas_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (!cur_active)
                    begin
                        arm_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = pas_pkg::ST_IDLE;
                    end
                    else if (idx_reg == LAST_SLOT)
                        state_next = pas_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end

            pas_pkg::ST_OVERFLOW:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = pas_pkg::KIND_OVERFLOW;
                    out_next.fired_event = '0;
                    out_next.last        = 1'b1;
                    state_next           = pas_pkg::ST_IDLE;
                end
            end

            // Decide whether the current slot needs a remainder check
            pas_pkg::ST_TICK_CHECK:
            begin
                if (found_reg == pas_pkg::FOUND_W'(pas_pkg::MAX_RESULTS))
                    state_next = pas_pkg::ST_TICK_FLUSH;
                else if (cur_active && cur_period != '0)
                begin
                    sh_next    = now_reg;
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = pas_pkg::ST_TICK_DIV;
                end
                else if (idx_reg == LAST_SLOT)
                    state_next = pas_pkg::ST_TICK_FLUSH;
                else
                    idx_next = idx_reg + 1'b1;
            end

            // Advance the remainder one dividend bit per cycle
            pas_pkg::ST_TICK_DIV:
            begin
                if (trial >= divisor)
                    rem_next = diff[pas_pkg::PERIOD_W-1:0];
                else
                    rem_next = trial[pas_pkg::PERIOD_W-1:0];
                sh_next  = {sh_reg[pas_pkg::TIME_W-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == LAST_BIT)
                    state_next = pas_pkg::ST_TICK_FIRE;
            end

            // Fire on zero remainder; release the previous held result
            pas_pkg::ST_TICK_FIRE:
            begin
                if (rem_reg != '0 || !pend_valid_reg || out_free)
                begin
                    if (rem_reg == '0)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next       = 1'b1;
                            out_next.kind        = pas_pkg::KIND_FIRED;
                            out_next.fired_event = pend_event_reg;
                            out_next.last        = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_event_next = cur_event;
                        found_next      = found_reg + 1'b1;
                        if (!cur_periodic)
                        begin
                            free_we    = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    if (idx_reg == LAST_SLOT)
                        state_next = pas_pkg::ST_TICK_FLUSH;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = pas_pkg::ST_TICK_CHECK;
                    end
                end
            end

            // Drain the held result as the final beat of the tick
            pas_pkg::ST_TICK_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = pas_pkg::ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = pas_pkg::KIND_FIRED;
                    out_next.fired_event = pend_event_reg;
                    out_next.last        = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = pas_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pas_pkg::ST_IDLE;
            end
        endcase
    end

    // The count tracks the number of armed slots
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == pas_pkg::COUNT_W'($countones(active_reg)))
        else $error("active count out of step with slot table");

    // No held result survives into idle
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !pend_valid_reg)
        else $error("held result left behind at idle");

    // Overflow beats carry a zero id and close the item
    a_overflow_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.kind == pas_pkg::KIND_OVERFLOW) |->
            (evt.fired_event == '0 && evt.last))
        else $error("malformed overflow beat");

    // Never more results held back than the limit allows
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= pas_pkg::FOUND_W'(pas_pkg::MAX_RESULTS))
        else $error("result count past limit");

    // The table is written only once per cycle
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(arm_we && free_we))
        else $error("arm and free in one cycle");

endmodule
